// ===== rtl/assert_macros.svh =====
// assert_macros.svh
// Assertion helpers for the spotlight corona RTL; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SCI_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define SCI_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define SCI_ASSERT_SAME(lbl, clk, rst_n, pre, post)
`define SCI_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/sci_pkg.sv =====
// sci_pkg.sv
// Types and constants for the spotlight corona datapath.
// No dependencies.
`timescale 1ns / 1ps
package sci_pkg;

    localparam int POS_WIDTH = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_COS_INNER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COS_OUTER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_RED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LEVEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_EN   = 3'd6;

    localparam int NORM_BITS = 20;              // normalized magnitude width
    localparam int SUM_W     = 2 * NORM_BITS + 2;
    localparam int LEN_W     = SUM_W / 2;
    localparam int DIR_FRAC  = 14;
    localparam int DNUM_W    = NORM_BITS + DIR_FRAC + 1;
    localparam int QDIR_W    = DIR_FRAC + 1;
    localparam int DIR_W     = QDIR_W + 1;
    localparam int AIM_W     = 35;
    localparam int PROD_W    = DIR_W + AIM_W;
    localparam int DOT_W     = PROD_W + 2;
    localparam int ANG_W     = DOT_W - DIR_FRAC + 1;
    localparam int NUM_W     = ANG_W + 2;
    localparam int DIFF_W    = 17;
    localparam int OCC_W     = 16;
    localparam int OCC_NUM_W = OCC_W + DIFF_W;
    localparam int KEEP_W    = OCC_W + 1;
    localparam int TF_W      = 32;
    localparam int MIX_W     = TF_W + KEEP_W;
    localparam int MIX_SHIFT = 31;

    localparam logic signed [AIM_W-1:0] AIM_ONE  = 35'sh0_1000_0000;
    localparam logic [KEEP_W-1:0]       KEEP_ONE = 17'h1_0000;
    localparam logic [15:0]             FADE_MIN = 16'd32;

    typedef enum logic [1:0] {
        KEEP_ALL,
        KEEP_NONE,
        KEEP_DIV
    } keep_sel_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] cam_x;
        logic signed [POS_WIDTH-1:0] cam_y;
        logic signed [POS_WIDTH-1:0] cam_z;
        logic signed [POS_WIDTH-1:0] lamp_x;
        logic signed [POS_WIDTH-1:0] lamp_y;
        logic signed [POS_WIDTH-1:0] lamp_z;
        logic signed [15:0]          quat_w;
        logic signed [15:0]          quat_x;
        logic signed [15:0]          quat_y;
        logic signed [15:0]          quat_z;
    } req_t;

    typedef struct packed {
        logic [15:0] glow_red;
        logic [15:0] glow_green;
        logic [15:0] glow_blue;
        logic        lamp_visible;
    } res_t;

    typedef struct packed {
        logic signed [15:0] cos_inner;
        logic signed [15:0] cos_outer;
        logic [15:0]        tint_red;
        logic [15:0]        tint_green;
        logic [15:0]        tint_blue;
        logic [15:0]        fade_level;
        logic               light_en;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } quat_t;

    // travels beside the direction divider
    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
        quat_t      quat;
    } dir_tag_t;

    // travels beside the square root
    typedef struct packed {
        logic [2:0][NORM_BITS-1:0] mag;
        dir_tag_t                  tag;
    } dir_side_t;

endpackage

// ===== rtl/sci_norm.sv =====
// sci_norm.sv
// Light-to-camera difference, block normalization and sum of squares.
// Depends on sci_pkg.
`timescale 1ns / 1ps
module sci_norm (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_vld,
    input  sci_pkg::req_t            req,
    output logic                     out_vld,
    output logic [sci_pkg::SUM_W-1:0] sum,
    output sci_pkg::dir_side_t       side
);
    localparam int MW = sci_pkg::POS_WIDTH;
    localparam int PW = $clog2(MW + 1);
    localparam int NB = sci_pkg::NORM_BITS;

    logic [4:0] vld_reg;

    logic [2:0][MW-1:0] mag1_reg, mag1_next, mag2_reg;
    logic [2:0]         neg1_next;
    logic [2:0]         neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    sci_pkg::quat_t     q1_reg, q2_reg, q3_reg, q4_reg, q5_reg;
    logic [PW-1:0]      sh2_next, sh2_reg;
    logic               zero2_next;
    logic               zero2_reg, zero3_reg, zero4_reg, zero5_reg;
    logic [2:0][NB-1:0] mag3_next, mag3_reg, mag4_reg, mag5_reg;
    logic [2:0][2*NB-1:0] sq4_reg;
    logic [sci_pkg::SUM_W-1:0] sum5_reg;

    // stage 1: exact difference and sign
    always_comb
    begin
        logic signed [MW:0] ce [3];
        logic signed [MW:0] le [3];
        ce[0] = (MW+1)'(req.cam_x);
        ce[1] = (MW+1)'(req.cam_y);
        ce[2] = (MW+1)'(req.cam_z);
        le[0] = (MW+1)'(req.lamp_x);
        le[1] = (MW+1)'(req.lamp_y);
        le[2] = (MW+1)'(req.lamp_z);
        for (int i = 0; i < 3; i++)
        begin
            neg1_next[i] = ce[i] < le[i];
            mag1_next[i] = neg1_next[i] ? MW'(le[i] - ce[i]) : MW'(ce[i] - le[i]);
        end
    end

    // stage 2: leading one of the largest magnitude
    always_comb
    begin
        logic [MW-1:0] orv;
        orv = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        sh2_next = '0;
        for (int k = 0; k < MW; k++)
        begin
            if (orv[k])
                sh2_next = PW'(k + 1);
        end
        zero2_next = (orv == '0);
    end

    // stage 3: bring the top bit to NB-1
    always_comb
    begin
        logic [MW+NB-1:0] ext;
        for (int i = 0; i < 3; i++)
        begin
            ext = {mag2_reg[i], {NB{1'b0}}} >> sh2_reg;
            mag3_next[i] = ext[NB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[3:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        mag1_reg  <= mag1_next;
        neg1_reg  <= neg1_next;
        q1_reg    <= {req.quat_w, req.quat_x, req.quat_y, req.quat_z};
        mag2_reg  <= mag1_reg;
        neg2_reg  <= neg1_reg;
        q2_reg    <= q1_reg;
        sh2_reg   <= sh2_next;
        zero2_reg <= zero2_next;
        mag3_reg  <= mag3_next;
        neg3_reg  <= neg2_reg;
        q3_reg    <= q2_reg;
        zero3_reg <= zero2_reg;
        for (int i = 0; i < 3; i++)
            sq4_reg[i] <= mag3_reg[i] * mag3_reg[i];
        mag4_reg  <= mag3_reg;
        neg4_reg  <= neg3_reg;
        q4_reg    <= q3_reg;
        zero4_reg <= zero3_reg;
        sum5_reg  <= sci_pkg::SUM_W'(sq4_reg[0]) + sci_pkg::SUM_W'(sq4_reg[1])
                   + sci_pkg::SUM_W'(sq4_reg[2]);
        mag5_reg  <= mag4_reg;
        neg5_reg  <= neg4_reg;
        q5_reg    <= q4_reg;
        zero5_reg <= zero4_reg;
    end

    assign out_vld       = vld_reg[4];
    assign sum           = sum5_reg;
    assign side.mag      = mag5_reg;
    assign side.tag.neg  = neg5_reg;
    assign side.tag.zero = zero5_reg;
    assign side.tag.quat = q5_reg;

endmodule

// ===== rtl/sci_sqrt.sv =====
// sci_sqrt.sv
// Pipelined digit-by-digit floor square root with a pass-along side field.
// No package dependencies.
`timescale 1ns / 1ps
module sci_sqrt #(
    parameter int VW  = 42,
    parameter int SPS = 3,
    parameter int SW  = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_vld,
    input  logic [VW-1:0]   val,
    input  logic [SW-1:0]   side_in,
    output logic            out_vld,
    output logic [VW/2-1:0] root,
    output logic [SW-1:0]   side_out
);
    localparam int RW  = VW / 2;
    localparam int NST = (RW + SPS - 1) / SPS;

    logic [NST-1:0] vld_reg;
    logic [RW:0]    rem_reg  [NST];
    logic [RW-1:0]  root_reg [NST];
    logic [VW-1:0]  val_reg  [NST];
    logic [SW-1:0]  side_reg [NST];

    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        logic          vld_in;
        logic [RW:0]   rem_in, rem_next;
        logic [RW-1:0] root_in, root_next;
        logic [VW-1:0] val_in, val_next;
        logic [SW-1:0] side_s;

        if (s == 0)
        begin : g_head
            assign vld_in  = in_vld;
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = val;
            assign side_s  = side_in;
        end
        else
        begin : g_body
            assign vld_in  = vld_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign val_in  = val_reg[s-1];
            assign side_s  = side_reg[s-1];
        end

        always_comb
        begin
            logic [RW+2:0] t;
            logic [RW+2:0] trial;
            rem_next  = rem_in;
            root_next = root_in;
            val_next  = val_in;
            for (int j = 0; j < SPS; j++)
            begin
                if (s * SPS + j < RW)
                begin
                    t     = {rem_next, val_next[VW-1 -: 2]};
                    trial = {1'b0, root_next, 2'b01};
                    if (t >= trial)
                    begin
                        t         = t - trial;
                        root_next = {root_next[RW-2:0], 1'b1};
                    end
                    else
                        root_next = {root_next[RW-2:0], 1'b0};
                    rem_next = t[RW:0];
                    val_next = {val_next[VW-3:0], 2'b00};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= rem_next;
            root_reg[s] <= root_next;
            val_reg[s]  <= val_next;
            side_reg[s] <= side_s;
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign root     = root_reg[NST-1];
    assign side_out = side_reg[NST-1];

endmodule

// ===== rtl/sci_div.sv =====
// sci_div.sv
// Pipelined restoring divider, several lanes sharing one divisor.
// Expects num >> QW to be below den. No package dependencies.
`timescale 1ns / 1ps
module sci_div #(
    parameter int LANES = 1,
    parameter int NW    = 33,
    parameter int DW    = 17,
    parameter int QW    = 16,
    parameter int SPS   = 4,
    parameter int SW    = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_vld,
    input  logic [LANES-1:0][NW-1:0]    num,
    input  logic [DW-1:0]               den,
    input  logic [SW-1:0]               side_in,
    output logic                        out_vld,
    output logic [LANES-1:0][QW-1:0]    quo,
    output logic [SW-1:0]               side_out
);
    localparam int NST = (QW + SPS - 1) / SPS;

    logic [NST-1:0]           vld_reg;
    logic [DW-1:0]            den_reg  [NST];
    logic [LANES-1:0][DW-1:0] rem_reg  [NST];
    logic [LANES-1:0][QW-1:0] wrk_reg  [NST];
    logic [SW-1:0]            side_reg [NST];

    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        logic                     vld_in;
        logic [DW-1:0]            den_in;
        logic [LANES-1:0][DW-1:0] rem_in, rem_next;
        logic [LANES-1:0][QW-1:0] wrk_in, wrk_next;
        logic [SW-1:0]            side_s;

        if (s == 0)
        begin : g_head
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_in[l] = DW'(num[l][NW-1:QW]);
                    wrk_in[l] = num[l][QW-1:0];
                end
            end
            assign vld_in = in_vld;
            assign den_in = den;
            assign side_s = side_in;
        end
        else
        begin : g_body
            assign vld_in = vld_reg[s-1];
            assign den_in = den_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign wrk_in = wrk_reg[s-1];
            assign side_s = side_reg[s-1];
        end

        // wrk shifts dividend bits out at the top and quotient bits in below
        always_comb
        begin
            logic [DW:0] t;
            rem_next = rem_in;
            wrk_next = wrk_in;
            for (int l = 0; l < LANES; l++)
            begin
                for (int j = 0; j < SPS; j++)
                begin
                    if (s * SPS + j < QW)
                    begin
                        t = {rem_next[l], wrk_next[l][QW-1]};
                        if (t >= {1'b0, den_in})
                        begin
                            t = t - {1'b0, den_in};
                            wrk_next[l] = {wrk_next[l][QW-2:0], 1'b1};
                        end
                        else
                            wrk_next[l] = {wrk_next[l][QW-2:0], 1'b0};
                        rem_next[l] = t[DW-1:0];
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            den_reg[s]  <= den_in;
            rem_reg[s]  <= rem_next;
            wrk_reg[s]  <= wrk_next;
            side_reg[s] <= side_s;
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign quo      = wrk_reg[NST-1];
    assign side_out = side_reg[NST-1];

endmodule

// ===== rtl/sci_shade.sv =====
// sci_shade.sv
// Aim from quaternion, cone dot product, occlusion and colour output.
// Depends on sci_pkg and sci_div.
`timescale 1ns / 1ps
module sci_shade (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_vld,
    input  logic [2:0][sci_pkg::QDIR_W-1:0]     quo,
    input  sci_pkg::dir_tag_t                   tag,
    input  sci_pkg::cfg_t                       cfg,
    output logic                                out_vld,
    output sci_pkg::res_t                       result
);
    localparam int DIR_W     = sci_pkg::DIR_W;
    localparam int AIM_W     = sci_pkg::AIM_W;
    localparam int PROD_W    = sci_pkg::PROD_W;
    localparam int DOT_W     = sci_pkg::DOT_W;
    localparam int ANG_W     = sci_pkg::ANG_W;
    localparam int NUM_W     = sci_pkg::NUM_W;
    localparam int DIFF_W    = sci_pkg::DIFF_W;
    localparam int OCC_W     = sci_pkg::OCC_W;
    localparam int OCC_NUM_W = sci_pkg::OCC_NUM_W;
    localparam int KEEP_W    = sci_pkg::KEEP_W;
    localparam int TF_W      = sci_pkg::TF_W;
    localparam int MIX_W     = sci_pkg::MIX_W;
    localparam int FRAC      = sci_pkg::DIR_FRAC;

    logic [5:0] vld_reg;
    logic       s7_vld_reg, s8_vld_reg, out_vld_reg;

    logic [2:0][DIR_W-1:0] dir1_next, dir1_reg, dir2_reg;
    logic signed [31:0] xy1_reg, wz1_reg, xx1_reg, zz1_reg, wx1_reg, yz1_reg;
    logic signed [AIM_W-1:0] aim2_next [3];
    logic signed [AIM_W-1:0] aim2_reg  [3];
    logic signed [PROD_W-1:0] p3_reg [3];
    logic signed [DOT_W-1:0] dot4_reg;
    logic signed [ANG_W-1:0] ang5_next, ang5_reg;
    logic [OCC_NUM_W-1:0] num6_next, num6_reg;
    logic [DIFF_W-1:0]    den6_next, den6_reg;
    sci_pkg::keep_sel_t   sel6_next, sel6_reg, sel_dv;

    logic                 dv_vld;
    logic [0:0][OCC_W-1:0] dv_quo;
    logic [1:0]           dv_side;

    logic [KEEP_W-1:0] keep7_next, keep7_reg;
    logic [2:0][TF_W-1:0]  tf_reg;
    logic [2:0][MIX_W-1:0] mix8_reg;
    logic [2:0][15:0]      tint;
    logic [2:0][15:0]      glow_next;
    sci_pkg::res_t         res_reg;

    // stage 1: signed direction, quaternion products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (tag.zero)
                dir1_next[i] = '0;
            else if (tag.neg[i])
                dir1_next[i] = -DIR_W'(quo[i]);
            else
                dir1_next[i] = DIR_W'(quo[i]);
        end
    end

    // stage 2: aim = q * (0,1,0) * q'
    always_comb
    begin
        aim2_next[0] = (AIM_W'(xy1_reg) - AIM_W'(wz1_reg)) <<< 1;
        aim2_next[1] = sci_pkg::AIM_ONE - ((AIM_W'(xx1_reg) + AIM_W'(zz1_reg)) <<< 1);
        aim2_next[2] = (AIM_W'(wx1_reg) + AIM_W'(yz1_reg)) <<< 1;
    end

    // stage 5: round the dot product half away from zero
    always_comb
    begin
        logic [DOT_W-1:0] dmag;
        logic [DOT_W-1:0] rnd;
        dmag = dot4_reg[DOT_W-1] ? DOT_W'(-dot4_reg) : DOT_W'(dot4_reg);
        rnd  = (dmag + (DOT_W'(1) << (FRAC - 1))) >> FRAC;
        ang5_next = dot4_reg[DOT_W-1] ? -ANG_W'(rnd) : ANG_W'(rnd);
    end

    // stage 6: place the angle within the cone edges
    always_comb
    begin
        logic signed [NUM_W-1:0]  num;
        logic signed [NUM_W-1:0]  thr;
        logic signed [DIFF_W-1:0] dd;
        num = NUM_W'(ang5_reg) - (NUM_W'(cfg.cos_inner) <<< FRAC);
        dd  = DIFF_W'(cfg.cos_outer) - DIFF_W'(cfg.cos_inner);
        if (dd < 0)
        begin
            num = -num;
            dd  = -dd;
        end
        thr = NUM_W'(dd) <<< FRAC;
        if (dd == '0 || num <= 0)
            sel6_next = sci_pkg::KEEP_ALL;
        else if (num >= thr)
            sel6_next = sci_pkg::KEEP_NONE;
        else
            sel6_next = sci_pkg::KEEP_DIV;
        // num * 2^16 / (dd * 2^14) reduces to num * 4 / dd
        num6_next = {num[OCC_NUM_W-3:0], 2'b00};
        den6_next = dd;
    end

    sci_div #(
        .LANES (1),
        .NW    (OCC_NUM_W),
        .DW    (DIFF_W),
        .QW    (OCC_W),
        .SPS   (4),
        .SW    (2)
    ) u_occ_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vld_reg[5]),
        .num      (num6_reg),
        .den      (den6_reg),
        .side_in  (sel6_reg),
        .out_vld  (dv_vld),
        .quo      (dv_quo),
        .side_out (dv_side)
    );

    assign sel_dv = sci_pkg::keep_sel_t'(dv_side);

    always_comb
    begin
        unique case (sel_dv)
            sci_pkg::KEEP_ALL:  keep7_next = sci_pkg::KEEP_ONE;
            sci_pkg::KEEP_NONE: keep7_next = '0;
            sci_pkg::KEEP_DIV:  keep7_next = sci_pkg::KEEP_ONE - KEEP_W'(dv_quo[0]);
            default:            keep7_next = '0;
        endcase
    end

    assign tint = {cfg.tint_blue, cfg.tint_green, cfg.tint_red};

    // final stage: round once, saturate, gate by enable
    always_comb
    begin
        logic [MIX_W:0] r;
        for (int c = 0; c < 3; c++)
        begin
            r = ((MIX_W+1)'(mix8_reg[c]) + ((MIX_W+1)'(1) << (sci_pkg::MIX_SHIFT - 1)))
                >> sci_pkg::MIX_SHIFT;
            if (!cfg.light_en)
                glow_next[c] = '0;
            else if (r > (MIX_W+1)'(16'hFFFF))
                glow_next[c] = 16'hFFFF;
            else
                glow_next[c] = r[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= {vld_reg[4:0], in_vld};
            s7_vld_reg  <= dv_vld;
            s8_vld_reg  <= s7_vld_reg;
            out_vld_reg <= s8_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dir1_reg <= dir1_next;
        xy1_reg  <= tag.quat.quat_x * tag.quat.quat_y;
        wz1_reg  <= tag.quat.quat_w * tag.quat.quat_z;
        xx1_reg  <= tag.quat.quat_x * tag.quat.quat_x;
        zz1_reg  <= tag.quat.quat_z * tag.quat.quat_z;
        wx1_reg  <= tag.quat.quat_w * tag.quat.quat_x;
        yz1_reg  <= tag.quat.quat_y * tag.quat.quat_z;
        dir2_reg <= dir1_reg;
        for (int i = 0; i < 3; i++)
        begin
            aim2_reg[i] <= aim2_next[i];
            p3_reg[i]   <= $signed(dir2_reg[i]) * aim2_reg[i];
        end
        dot4_reg <= DOT_W'(p3_reg[0]) + DOT_W'(p3_reg[1]) + DOT_W'(p3_reg[2]);
        ang5_reg <= ang5_next;
        num6_reg <= num6_next;
        den6_reg <= den6_next;
        sel6_reg <= sel6_next;
        keep7_reg <= keep7_next;
        for (int c = 0; c < 3; c++)
        begin
            tf_reg[c]   <= tint[c] * cfg.fade_level;
            mix8_reg[c] <= tf_reg[c] * keep7_reg;
        end
        res_reg.glow_red     <= glow_next[0];
        res_reg.glow_green   <= glow_next[1];
        res_reg.glow_blue    <= glow_next[2];
        res_reg.lamp_visible <= cfg.light_en && (cfg.fade_level > sci_pkg::FADE_MIN);
    end

    assign out_vld = out_vld_reg;
    assign result  = res_reg;

endmodule

// ===== rtl/spotlight_corona_intensity.sv =====
// spotlight_corona_intensity.sv
// Top level: configuration registers and the spotlight cone pipeline.
// Depends on sci_pkg, sci_norm, sci_sqrt, sci_div, sci_shade, assert_macros.svh.
//
// Usage:
//  - Request channel: drive req and pulse start; a request is taken at every
//    rising edge with start high and busy low. busy is always low, so one
//    request per cycle is accepted.
//  - Result channel: done is high for exactly one cycle with result valid.
//    There is no back-pressure; results must be captured when done is high.
//  - Throughput: one request per cycle.
//  - The pipeline is made of the front end (5 stages), the square root
//    (7 stages, 3 root bits each), the direction divider (3 stages, 5 bits
//    each), 6 shading stages, the occlusion divider (4 stages, 4 bits each)
//    and 3 colour stages.
//  - Configuration: cfg_wr writes cfg_data to register cfg_idx at the edge;
//    indexes past the light enable are ignored. Write only when idle.
//  - Reset clears the pipeline valids and loads the register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spotlight_corona_intensity (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  sci_pkg::req_t                     req,
    output logic                              done,
    output sci_pkg::res_t                     result,
    input  logic                              cfg_wr,
    input  logic [sci_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [sci_pkg::CFG_DATA_W-1:0]    cfg_data
);
    sci_pkg::cfg_t cfg_reg, cfg_next;

    logic                          norm_vld;
    logic [sci_pkg::SUM_W-1:0]     norm_sum;
    sci_pkg::dir_side_t            norm_side;
    logic                          sq_vld;
    logic [sci_pkg::LEN_W-1:0]     sq_len;
    sci_pkg::dir_side_t            sq_side;
    logic [2:0][sci_pkg::DNUM_W-1:0] dv_num;
    logic                          dv_vld;
    logic [2:0][sci_pkg::QDIR_W-1:0] dv_quo;
    sci_pkg::dir_tag_t             dv_tag;

    assign busy = 1'b0;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                sci_pkg::REG_COS_INNER:  cfg_next.cos_inner  = cfg_data;
                sci_pkg::REG_COS_OUTER:  cfg_next.cos_outer  = cfg_data;
                sci_pkg::REG_TINT_RED:   cfg_next.tint_red   = cfg_data;
                sci_pkg::REG_TINT_GREEN: cfg_next.tint_green = cfg_data;
                sci_pkg::REG_TINT_BLUE:  cfg_next.tint_blue  = cfg_data;
                sci_pkg::REG_FADE_LEVEL: cfg_next.fade_level = cfg_data;
                sci_pkg::REG_LIGHT_EN:   cfg_next.light_en   = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_inner  <= 16'shC000;
            cfg_reg.cos_outer  <= 16'shC000;
            cfg_reg.tint_red   <= 16'd4096;
            cfg_reg.tint_green <= 16'd4096;
            cfg_reg.tint_blue  <= 16'd4096;
            cfg_reg.fade_level <= 16'd32768;
            cfg_reg.light_en   <= 1'b1;
        end
        else
            cfg_reg <= cfg_next;
    end

    sci_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (start && !busy),
        .req     (req),
        .out_vld (norm_vld),
        .sum     (norm_sum),
        .side    (norm_side)
    );

    sci_sqrt #(
        .VW  (sci_pkg::SUM_W),
        .SPS (3),
        .SW  ($bits(sci_pkg::dir_side_t))
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (norm_vld),
        .val      (norm_sum),
        .side_in  (norm_side),
        .out_vld  (sq_vld),
        .root     (sq_len),
        .side_out (sq_side)
    );

    // round(mag * 2^14 / len) as floor((mag * 2^14 + len / 2) / len)
    always_comb
    begin
        for (int l = 0; l < 3; l++)
            dv_num[l] = sci_pkg::DNUM_W'({sq_side.mag[l], {sci_pkg::DIR_FRAC{1'b0}}})
                      + sci_pkg::DNUM_W'(sq_len >> 1);
    end

    sci_div #(
        .LANES (3),
        .NW    (sci_pkg::DNUM_W),
        .DW    (sci_pkg::LEN_W),
        .QW    (sci_pkg::QDIR_W),
        .SPS   (5),
        .SW    ($bits(sci_pkg::dir_tag_t))
    ) u_dir_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (sq_vld),
        .num      (dv_num),
        .den      (sq_len),
        .side_in  (sq_side.tag),
        .out_vld  (dv_vld),
        .quo      (dv_quo),
        .side_out (dv_tag)
    );

    sci_shade u_shade (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (dv_vld),
        .quo     (dv_quo),
        .tag     (dv_tag),
        .cfg     (cfg_reg),
        .out_vld (done),
        .result  (result)
    );

    `SCI_ASSERT_NEXT(a_off_dark, clk, rst_n, !cfg_reg.light_en, !done || (result.glow_red == '0 && result.glow_green == '0 && result.glow_blue == '0 && !result.lamp_visible))
    `SCI_ASSERT_SAME(a_vis_fade, clk, rst_n, done && result.lamp_visible, $past(cfg_reg.fade_level) > sci_pkg::FADE_MIN)

endmodule
